// ===== rtl/core/tdhe_pkg.sv =====
// shared types, constants and codes of the two-dimensional histogram equaliser
`timescale 1ns / 1ps
package tdhe_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int LEVELS     = 256;
    localparam int BIN_BITS   = 40;
    localparam int TOT_BITS   = BIN_BITS + 8;
    localparam int REM_BITS   = TOT_BITS + 8;
    localparam int ACC_BITS   = 24;

    localparam logic       REQ_LOAD  = 1'b0;
    localparam logic       REQ_READ  = 1'b1;
    localparam logic       RESP_ACK  = 1'b0;
    localparam logic       RESP_PIX  = 1'b1;
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [15:0] pixel_index;
        logic [7:0]  pixel_value;
        logic        last_pixel;
    } t_req;

    typedef struct packed {
        logic       resp_type;
        logic [7:0] out_value;
    } t_resp;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_CLR, ST_PXV, ST_PXV2, ST_WIN, ST_DRAIN,
        ST_HWR, ST_TOT, ST_TOTD, ST_CRD, ST_CADD, ST_DIV, ST_MWR, ST_ACK
    } t_state;

    typedef struct packed {
        logic host_wr;
        logic map_rd;
        logic clr;
        logic px_rd;
        logic v_latch;
        logic win_issue;
        logic drain;
        logic h_wr;
        logic tot_issue;
        logic tot_end;
        logic c_rd;
        logic c_add;
        logic div_step;
        logic m_wr;
        logic out_pix;
        logic out_ack;
    } t_cmd;

    typedef struct packed {
        logic lv_last;
        logic px_last;
        logic win_last;
        logic rad_zero;
        logic div_last;
    } t_sts;

endpackage

// ===== rtl/core/tdhe_ctrl.sv =====
// controller state machine of the equaliser
`timescale 1ns / 1ps
module tdhe_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  tdhe_pkg::t_req i_req,
    input  tdhe_pkg::t_sts i_sts,
    output tdhe_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    tdhe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdhe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tdhe_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_req.req_type == tdhe_pkg::REQ_READ) n_state = tdhe_pkg::ST_RD1;
                    else if (i_req.last_pixel) n_state = tdhe_pkg::ST_CLR;
                end
            end
            tdhe_pkg::ST_RD1:   n_state = tdhe_pkg::ST_RD2;
            tdhe_pkg::ST_RD2:   n_state = tdhe_pkg::ST_IDLE;
            tdhe_pkg::ST_CLR:   if (i_sts.lv_last) n_state = tdhe_pkg::ST_PXV;
            tdhe_pkg::ST_PXV:   n_state = tdhe_pkg::ST_PXV2;
            tdhe_pkg::ST_PXV2:  n_state = i_sts.rad_zero ? tdhe_pkg::ST_DRAIN : tdhe_pkg::ST_WIN;
            tdhe_pkg::ST_WIN:   if (i_sts.win_last) n_state = tdhe_pkg::ST_DRAIN;
            tdhe_pkg::ST_DRAIN: n_state = tdhe_pkg::ST_HWR;
            tdhe_pkg::ST_HWR:   n_state = i_sts.px_last ? tdhe_pkg::ST_TOT : tdhe_pkg::ST_PXV;
            tdhe_pkg::ST_TOT:   if (i_sts.lv_last) n_state = tdhe_pkg::ST_TOTD;
            tdhe_pkg::ST_TOTD:  n_state = tdhe_pkg::ST_CRD;
            tdhe_pkg::ST_CRD:   n_state = tdhe_pkg::ST_CADD;
            tdhe_pkg::ST_CADD:  n_state = tdhe_pkg::ST_DIV;
            tdhe_pkg::ST_DIV:   if (i_sts.div_last) n_state = tdhe_pkg::ST_MWR;
            tdhe_pkg::ST_MWR:   n_state = i_sts.lv_last ? tdhe_pkg::ST_ACK : tdhe_pkg::ST_CRD;
            tdhe_pkg::ST_ACK:   n_state = tdhe_pkg::ST_IDLE;
            default:            n_state = tdhe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = (r_state != tdhe_pkg::ST_IDLE);
        case (r_state)
            tdhe_pkg::ST_IDLE:  o_cmd.host_wr = i_start && (i_req.req_type == tdhe_pkg::REQ_LOAD);
            tdhe_pkg::ST_RD1:   o_cmd.map_rd = 1'b1;
            tdhe_pkg::ST_RD2:   o_cmd.out_pix = 1'b1;
            tdhe_pkg::ST_CLR:   o_cmd.clr = 1'b1;
            tdhe_pkg::ST_PXV:   o_cmd.px_rd = 1'b1;
            tdhe_pkg::ST_PXV2:  o_cmd.v_latch = 1'b1;
            tdhe_pkg::ST_WIN:   o_cmd.win_issue = 1'b1;
            tdhe_pkg::ST_DRAIN: o_cmd.drain = 1'b1;
            tdhe_pkg::ST_HWR:   o_cmd.h_wr = 1'b1;
            tdhe_pkg::ST_TOT:   o_cmd.tot_issue = 1'b1;
            tdhe_pkg::ST_TOTD:  o_cmd.tot_end = 1'b1;
            tdhe_pkg::ST_CRD:   o_cmd.c_rd = 1'b1;
            tdhe_pkg::ST_CADD:  o_cmd.c_add = 1'b1;
            tdhe_pkg::ST_DIV:   o_cmd.div_step = 1'b1;
            tdhe_pkg::ST_MWR:   o_cmd.m_wr = 1'b1;
            tdhe_pkg::ST_ACK:   o_cmd.out_ack = 1'b1;
            default:            o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/core/tdhe_dp.sv =====
// datapath of the equaliser: stores, counters, window accumulator, divider
`timescale 1ns / 1ps
module tdhe_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tdhe_pkg::t_req i_req,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [8:0]     i_cfg_data,
    input  tdhe_pkg::t_cmd i_cmd,
    output tdhe_pkg::t_sts o_sts,
    output tdhe_pkg::t_resp o_resp
);

    logic [8:0] r_width, r_height;
    logic [5:0] r_radius;
    logic [8:0] w_eff, h_eff;

    logic [7:0] frame_mem [0:tdhe_pkg::MAX_WIDTH*tdhe_pkg::MAX_HEIGHT-1];
    logic [tdhe_pkg::BIN_BITS-1:0] hist_mem [0:tdhe_pkg::LEVELS-1];
    logic [7:0] map_mem [0:tdhe_pkg::LEVELS-1];

    logic [7:0]  r_fdata, r_mdata, r_v, r_row, r_col, r_lv, r_q;
    logic        r_s1, r_tv, r_map_ok;
    logic signed [9:0] r_m, r_n;
    logic [tdhe_pkg::ACC_BITS-1:0] r_acc;
    logic [tdhe_pkg::BIN_BITS-1:0] r_hdata;
    logic [tdhe_pkg::TOT_BITS-1:0] r_total, r_cum;
    logic [tdhe_pkg::REM_BITS-1:0] r_rem;
    logic [2:0]  r_k;

    logic signed [9:0] m_beg, n_beg, m_end, n_end;
    logic [7:0]  row_sel, col_sel, cl_m, cl_n, hist_addr;
    logic [16:0] prod;
    logic [15:0] faddr;
    logic [7:0]  diff;
    logic [tdhe_pkg::BIN_BITS:0] hsum;
    logic [tdhe_pkg::BIN_BITS-1:0] hsat;
    logic [tdhe_pkg::TOT_BITS-1:0] cum_nx;
    logic [tdhe_pkg::REM_BITS-1:0] tsh;

    // frame size clamped to 1..max
    always_comb begin
        w_eff = (r_width == 9'd0) ? 9'd1 :
                (r_width > 9'(tdhe_pkg::MAX_WIDTH)) ? 9'(tdhe_pkg::MAX_WIDTH) : r_width;
        h_eff = (r_height == 9'd0) ? 9'd1 :
                (r_height > 9'(tdhe_pkg::MAX_HEIGHT)) ? 9'(tdhe_pkg::MAX_HEIGHT) : r_height;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'(tdhe_pkg::MAX_WIDTH);
            r_height <= 9'(tdhe_pkg::MAX_HEIGHT);
            r_radius <= 6'd31;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tdhe_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                tdhe_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                tdhe_pkg::CFG_RADIUS: r_radius <= i_cfg_data[5:0];
                default:              ;
            endcase
        end
    end

    // window bounds and clamped sample coordinates
    always_comb begin
        m_beg = $signed({2'b00, r_row}) - $signed({4'b0000, r_radius});
        n_beg = $signed({2'b00, r_col}) - $signed({4'b0000, r_radius});
        m_end = $signed({2'b00, r_row}) + $signed({4'b0000, r_radius}) - 10'sd1;
        n_end = $signed({2'b00, r_col}) + $signed({4'b0000, r_radius}) - 10'sd1;
        if (r_m < 0) cl_m = 8'd0;
        else if (r_m >= $signed({1'b0, h_eff})) cl_m = 8'(h_eff - 9'd1);
        else cl_m = r_m[7:0];
        if (r_n < 0) cl_n = 8'd0;
        else if (r_n >= $signed({1'b0, w_eff})) cl_n = 8'(w_eff - 9'd1);
        else cl_n = r_n[7:0];
        row_sel = i_cmd.win_issue ? cl_m : r_row;
        col_sel = i_cmd.win_issue ? cl_n : r_col;
        prod    = row_sel * w_eff + {9'd0, col_sel};
        faddr   = (i_cmd.win_issue || i_cmd.px_rd) ? prod[15:0] : i_req.pixel_index;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.host_wr) frame_mem[faddr] <= i_req.pixel_value;
        r_fdata <= frame_mem[faddr];
    end

    // histogram store
    always_comb begin
        hist_addr = (i_cmd.drain || i_cmd.h_wr) ? r_v : r_lv;
        hsum      = {1'b0, r_hdata} + {{(tdhe_pkg::BIN_BITS+1-tdhe_pkg::ACC_BITS){1'b0}}, r_acc};
        hsat      = hsum[tdhe_pkg::BIN_BITS] ? '1 : hsum[tdhe_pkg::BIN_BITS-1:0];
        diff      = (r_v > r_fdata) ? (r_v - r_fdata) : (r_fdata - r_v);
        cum_nx    = r_cum + {8'd0, r_hdata};
        tsh       = {8'd0, r_total} << r_k;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) hist_mem[hist_addr] <= '0;
        else if (i_cmd.h_wr) hist_mem[hist_addr] <= hsat;
        r_hdata <= hist_mem[hist_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.m_wr) map_mem[r_lv] <= (r_total == '0) ? 8'd0 : r_q;
        r_mdata <= map_mem[r_fdata];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_ok <= 1'b0;
            r_lv     <= '0;
            r_s1     <= 1'b0;
            r_tv     <= 1'b0;
            r_k      <= '0;
        end else begin
            r_s1 <= i_cmd.win_issue;
            r_tv <= i_cmd.tot_issue;
            if (i_cmd.out_ack) r_map_ok <= 1'b1;
            if (i_cmd.clr || i_cmd.tot_issue || i_cmd.m_wr) r_lv <= r_lv + 8'd1;
            if (i_cmd.c_add) r_k <= 3'd7;
            else if (i_cmd.div_step) r_k <= r_k - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_row   <= '0;
            r_col   <= '0;
            r_total <= '0;
        end
        if (i_cmd.px_rd) begin
            r_m <= m_beg;
            r_n <= n_beg;
        end
        if (i_cmd.v_latch) begin
            r_v   <= r_fdata;
            r_acc <= '0;
        end
        if (i_cmd.win_issue) begin
            if (r_n == n_end) begin
                r_n <= n_beg;
                r_m <= r_m + 10'sd1;
            end else begin
                r_n <= r_n + 10'sd1;
            end
        end
        if (r_s1) r_acc <= r_acc + {{(tdhe_pkg::ACC_BITS-8){1'b0}}, diff} + 1'b1;
        if (i_cmd.h_wr) begin
            if ({1'b0, r_col} == w_eff - 9'd1) begin
                r_col <= '0;
                r_row <= r_row + 8'd1;
            end else begin
                r_col <= r_col + 8'd1;
            end
        end
        if (r_tv) r_total <= r_total + {8'd0, r_hdata};
        if (i_cmd.tot_end) r_cum <= '0;
        if (i_cmd.c_add) begin
            r_cum <= cum_nx;
            r_rem <= {cum_nx, 8'd0} - {8'd0, cum_nx};
            r_q   <= '0;
        end
        if (i_cmd.div_step && (r_rem >= tsh)) begin
            r_rem    <= r_rem - tsh;
            r_q[r_k] <= 1'b1;
        end
    end

    always_comb begin
        o_sts.lv_last  = (r_lv == 8'(tdhe_pkg::LEVELS - 1));
        o_sts.px_last  = ({1'b0, r_row} == h_eff - 9'd1) && ({1'b0, r_col} == w_eff - 9'd1);
        o_sts.win_last = (r_m == m_end) && (r_n == n_end);
        o_sts.rad_zero = (r_radius == 6'd0);
        o_sts.div_last = (r_k == 3'd0);
        o_resp.resp_type = i_cmd.out_pix ? tdhe_pkg::RESP_PIX : tdhe_pkg::RESP_ACK;
        o_resp.out_value = (i_cmd.out_pix && r_map_ok) ? r_mdata : 8'd0;
    end

endmodule

// ===== rtl/core/two_d_histogram_equalizer.sv =====
// top level of the two-dimensional histogram equaliser
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------
//  request   | start / busy               | i_req  (load or read, index, value)
//  result    | o_res_strobe (one cycle)   | o_res  (ack or mapped grey level)
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// an ordinary load is written to the frame store without leaving idle and gives no result
// a read runs in order: frame store read, level map read, result strobe
// the final load builds the map: a histogram clear, then a window scan of
// 2R by 2R samples per pixel (one frame store read port, one sample a cycle),
// then the total, the cumulative division per level and an acknowledgement
// reset is synchronous; it restores the size and radius registers and makes
// reads return zero until a map is built; the frame store is undefined until written
// the receiver cannot stall, so every result is a single-cycle strobe
`timescale 1ns / 1ps
module two_d_histogram_equalizer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  tdhe_pkg::t_req  i_req,
    output logic            o_res_strobe,
    output tdhe_pkg::t_resp o_res,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [8:0]      i_cfg_data
);

    tdhe_pkg::t_cmd cmd;
    tdhe_pkg::t_sts sts;

    // configuration is only taken while no transaction is in flight
    assign o_cfg_ready = !busy;

    tdhe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    tdhe_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_resp      (o_res)
    );

    // one result per read or final load, marked for a single cycle
    assign o_res_strobe = cmd.out_pix || cmd.out_ack;

    // a result only ever closes a transaction in flight
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> busy) else $error("result outside a transaction");

    // results are never back to back
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe) else $error("result strobe held");

    // acknowledgements carry zero
    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.resp_type == tdhe_pkg::RESP_ACK) |-> (o_res.out_value == 8'd0))
        else $error("acknowledgement with non-zero value");

    // an accepted read always occupies the block
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.req_type == tdhe_pkg::REQ_READ) |=> busy)
        else $error("read accepted without going busy");

endmodule
